>>> rtl/swm_pkg.sv
`default_nettype none

package swm_pkg;

	// Width of the window size register
	localparam int unsigned CFG_BITS = 7;

	// Per-cycle command broadcast to every deque cell
	typedef struct packed {
		logic shift;   // pop the front entry: take the right neighbor's contents
		logic commit;  // finish the item: drop dominated entries, append sample
		logic clear;   // restart: treat the whole deque as empty
	} swm_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/swm_cell.sv
`default_nettype none

module swm_cell #(
	parameter int unsigned SAMPLE_BITS = 16,
	parameter int unsigned POS_BITS = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  swm_pkg::swm_ctrl_t            ctrl,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic [POS_BITS-1:0]           sample_pos,
	input  logic                          right_valid,
	input  logic signed [SAMPLE_BITS-1:0] right_value,
	input  logic [POS_BITS-1:0]           right_pos,
	input  logic                          left_kept,
	output logic                          valid,
	output logic signed [SAMPLE_BITS-1:0] value,
	output logic [POS_BITS-1:0]           position,
	output logic                          kept,
	output logic signed [SAMPLE_BITS-1:0] next_value
);

	logic                          valid_q;
	logic signed [SAMPLE_BITS-1:0] value_q;
	logic [POS_BITS-1:0]           pos_q;

	logic                          view_valid;
	logic signed [SAMPLE_BITS-1:0] view_value;
	logic [POS_BITS-1:0]           view_pos;
	logic                          append;
	logic                          next_valid;
	logic [POS_BITS-1:0]           next_pos;

	// Select own or neighbor contents depending on a front pop
	always_comb begin
		if (ctrl.shift) begin
			view_valid = right_valid;
			view_value = right_value;
			view_pos   = right_pos;
		end else begin
			view_valid = valid_q;
			view_value = value_q;
			view_pos   = pos_q;
		end
		if (ctrl.clear) begin
			view_valid = 1'b0;
		end
	end

	// Keep entries greater than the sample; append in the first free slot
	assign kept   = view_valid & (view_value > sample);
	assign append = ~kept & left_kept;

	always_comb begin
		if (ctrl.commit) begin
			next_valid = kept | append;
			next_value = append ? sample : view_value;
			next_pos   = append ? sample_pos : view_pos;
		end else begin
			next_valid = view_valid;
			next_value = view_value;
			next_pos   = view_pos;
		end
	end

	// Clear valid bit under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift || ctrl.commit) begin
			valid_q <= next_valid;
		end
	end

	// Advance payload
	always_ff @(posedge clk) begin
		if (ctrl.shift || ctrl.commit) begin
			value_q <= next_value;
			pos_q   <= next_pos;
		end
	end

	assign valid    = valid_q;
	assign value    = value_q;
	assign position = pos_q;

endmodule

`default_nettype wire

>>> rtl/sliding_window_maximum_unit.sv
`default_nettype none

// Channel   Dir  Handshake          Payload
// s_*       in   s_tvalid/s_tready  s_tdata: sample; s_tuser: restart
// m_*       out  m_tvalid/m_tready  m_tdata: window_max
// window_*  in   window_size_we     window_size_wdata: window size (1..WINDOW_MAX)
//
// One sample is finished per cycle when at most one front entry ages out and the
// output is not stalled. Each further front entry that has aged out (only after the
// window size shrinks) is first popped in a step that shifts the chain by one place.
// Reset empties the deque, zeroes position and fill count, window size is 1.
// A stalled output holds its item; one more sample may wait in the input stage.

module sliding_window_maximum_unit #(
	parameter int unsigned WINDOW_MAX = 64,
	parameter int unsigned SAMPLE_BITS = 16,
	localparam int unsigned DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [DATA_BITS-1:0]          s_tdata,  // [SAMPLE_BITS-1:0] sample
	input  logic                          s_tuser,  // [0] restart
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [DATA_BITS-1:0]          m_tdata,  // [SAMPLE_BITS-1:0] window_max
	input  logic                          window_size_we,
	input  logic [swm_pkg::CFG_BITS-1:0]  window_size_wdata
);

	localparam int unsigned POS_MOD = 2 * WINDOW_MAX;
	localparam int unsigned PW = $clog2(POS_MOD);
	localparam int unsigned KW = $clog2(WINDOW_MAX + 1);

	logic [swm_pkg::CFG_BITS-1:0]  window_size_q;
	logic                          hold_v_q;
	logic signed [SAMPLE_BITS-1:0] hold_sample_q;
	logic                          hold_restart_q;
	logic [PW-1:0]                 pc_q;
	logic [KW-1:0]                 fill_q;
	logic                          m_tvalid_q;
	logic signed [SAMPLE_BITS-1:0] m_data_q;

	logic [KW-1:0]                 k_eff;
	logic [PW:0]                   age0;
	logic [PW:0]                   age1;
	logic                          aged0;
	logic                          aged1;
	logic                          out_ok;
	logic                          finish;
	logic                          step_fin;
	logic                          step_pop;
	logic [PW-1:0]                 pc_base;
	logic [PW-1:0]                 pc_next;
	logic [PW-1:0]                 append_pos;
	logic [KW-1:0]                 fill_base;
	logic [KW-1:0]                 fill_next;
	logic                          emit;
	swm_pkg::swm_ctrl_t            ctrl;

	logic                          cell_valid [WINDOW_MAX+1];
	logic signed [SAMPLE_BITS-1:0] cell_value [WINDOW_MAX+1];
	logic [PW-1:0]                 cell_pos   [WINDOW_MAX+1];
	logic                          cell_kept  [WINDOW_MAX+1];
	logic signed [SAMPLE_BITS-1:0] cell_next  [WINDOW_MAX];

	// Age of an entry, modulo the position range
	function automatic logic [PW:0] age_of(input logic [PW-1:0] pc, input logic [PW-1:0] pos);
		logic [PW:0] a;
		if (pc >= pos) begin
			a = {1'b0, pc} - {1'b0, pos};
		end else begin
			a = {1'b0, pc} + (PW+1)'(POS_MOD) - {1'b0, pos};
		end
		return a;
	endfunction

	// Clamp window size to 1..WINDOW_MAX
	always_comb begin
		if (window_size_q == '0) begin
			k_eff = KW'(1);
		end else if (32'(window_size_q) > WINDOW_MAX) begin
			k_eff = KW'(WINDOW_MAX);
		end else begin
			k_eff = KW'(window_size_q);
		end
	end

	// Check the two front entries for aging
	assign age0  = age_of(pc_q, cell_pos[0]);
	assign age1  = age_of(pc_q, cell_pos[1]);
	assign aged0 = cell_valid[0] & (age0 >= (PW+1)'(k_eff));
	assign aged1 = cell_valid[1] & (age1 >= (PW+1)'(k_eff));

	// Sequence the held item: pop extra aged entries, then finish
	assign out_ok   = ~m_tvalid_q | m_tready;
	assign finish   = hold_restart_q | ~(aged0 & aged1);
	assign step_fin = hold_v_q & finish & out_ok;
	assign step_pop = hold_v_q & ~finish;

	assign ctrl.shift  = (step_fin | step_pop) & aged0 & ~hold_restart_q;
	assign ctrl.commit = step_fin;
	assign ctrl.clear  = step_fin & hold_restart_q;

	assign s_tready = ~hold_v_q | step_fin;

	// Advance position and fill count
	assign pc_base    = hold_restart_q ? '0 : pc_q;
	assign append_pos = pc_base;
	assign pc_next    = (pc_base == PW'(POS_MOD - 1)) ? '0 : pc_base + PW'(1);
	assign fill_base  = hold_restart_q ? '0 : fill_q;
	assign fill_next  = (fill_base == KW'(WINDOW_MAX)) ? fill_base : fill_base + KW'(1);
	assign emit       = fill_next >= k_eff;

	// Tie off both ends of the chain
	assign cell_valid[WINDOW_MAX] = 1'b0;
	assign cell_value[WINDOW_MAX] = '0;
	assign cell_pos[WINDOW_MAX]   = '0;
	assign cell_kept[0]           = 1'b1;

	for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
		swm_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.POS_BITS    (PW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.sample      (hold_sample_q),
			.sample_pos  (append_pos),
			.right_valid (cell_valid[i+1]),
			.right_value (cell_value[i+1]),
			.right_pos   (cell_pos[i+1]),
			.left_kept   (cell_kept[i]),
			.valid       (cell_valid[i]),
			.value       (cell_value[i]),
			.position    (cell_pos[i]),
			.kept        (cell_kept[i+1]),
			.next_value  (cell_next[i])
		);
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= swm_pkg::CFG_BITS'(1);
			hold_v_q      <= 1'b0;
			pc_q          <= '0;
			fill_q        <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (window_size_we) begin
				window_size_q <= window_size_wdata;
			end
			if (s_tvalid && s_tready) begin
				hold_v_q <= 1'b1;
			end else if (step_fin) begin
				hold_v_q <= 1'b0;
			end
			if (step_fin) begin
				pc_q   <= pc_next;
				fill_q <= fill_next;
			end
			if (step_fin && emit) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Hold input item and result payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			hold_sample_q  <= s_tdata[SAMPLE_BITS-1:0];
			hold_restart_q <= s_tuser;
		end
		if (step_fin && emit) begin
			m_data_q <= cell_next[0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DATA_BITS'($unsigned(m_data_q));

endmodule

`default_nettype wire

>>> dv/window_max_checker.sv
`default_nettype none

module window_max_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [15:0]                  s_tdata,   // [15:0] sample
	input  logic                         s_tuser,   // [0] restart
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [15:0]                  m_tdata,   // [15:0] window_max
	input  logic                         window_size_we,
	input  logic [swm_pkg::CFG_BITS-1:0] window_size_wdata,
	output int                           mismatches,
	output int                           outstanding
);

	localparam int DEPTH = 64;
	localparam int MAX_PRINTED = 40;

	// Shadow of the window register and of the candidate deque
	logic [swm_pkg::CFG_BITS-1:0] window_reg;
	logic signed [15:0]           cand_value[$];
	logic [6:0]                   cand_pos[$];
	logic [6:0]                   next_pos;
	logic [6:0]                   stream_fill;
	logic signed [15:0]           expected_max_q[$];
	int                           printed;

	task automatic flag_mismatch(input string msg);
		if (printed < MAX_PRINTED) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
		printed++;
		mismatches++;
	endtask

	// Advance the deque by one sample and queue the window maximum once full
	task automatic take_sample(input logic signed [15:0] value, input logic restart);
		int span;
		span = (window_reg == 0) ? 1 : ((window_reg > DEPTH) ? DEPTH : int'(window_reg));
		if (restart) begin
			cand_value.delete();
			cand_pos.delete();
			next_pos = '0;
			stream_fill = '0;
		end
		// drop front entries that have left the window (age taken modulo 128)
		while (cand_pos.size() > 0 && int'(7'(next_pos - cand_pos[0])) >= span) begin
			cand_value.delete(0);
			cand_pos.delete(0);
		end
		// drop tail entries the new sample dominates
		while (cand_value.size() > 0 && cand_value[cand_value.size() - 1] <= value) begin
			cand_value.delete(cand_value.size() - 1);
			cand_pos.delete(cand_pos.size() - 1);
		end
		if (cand_value.size() < DEPTH) begin
			cand_value.insert(cand_value.size(), value);
			cand_pos.insert(cand_pos.size(), next_pos);
		end
		next_pos = next_pos + 7'd1;
		if (stream_fill < DEPTH) begin
			stream_fill = stream_fill + 7'd1;
		end
		if (int'(stream_fill) >= span) begin
			expected_max_q.insert(expected_max_q.size(), cand_value[0]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_reg = 7'd1;
			cand_value.delete();
			cand_pos.delete();
			next_pos = '0;
			stream_fill = '0;
			expected_max_q.delete();
		end else begin
			// compare each accepted result with the oldest expectation
			if (m_tvalid && m_tready) begin
				if (expected_max_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected result window_max=%0d",
						$signed(m_tdata)));
				end else begin
					logic signed [15:0] want;
					want = expected_max_q[0];
					expected_max_q.delete(0);
					if (m_tdata[15:0] !== want) begin
						flag_mismatch($sformatf("window_max got %0d, want %0d",
							$signed(m_tdata[15:0]), want));
					end
				end
			end
			if (s_tvalid && s_tready) begin
				take_sample($signed(s_tdata[15:0]), s_tuser);
			end
			if (window_size_we) begin
				window_reg = window_size_wdata;
			end
		end
		outstanding = expected_max_q.size();
	end

endmodule

`default_nettype wire

>>> dv/sliding_window_maximum_unit_tb.sv
`default_nettype none

module sliding_window_maximum_unit_tb;

	localparam int TOTAL_ITEMS = 1000;
	localparam int DRAIN_CYCLES = 150;
	localparam int LIMIT_CYCLES = 500000;

	typedef enum int {
		FULL_RANGE,
		NARROW,
		FALLING,
		RISING,
		EXTREMES
	} pattern_t;

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         s_tvalid = 1'b0;
	logic                         s_tready;
	logic [15:0]                  s_tdata = '0;   // [15:0] sample
	logic                         s_tuser = 1'b0; // [0] restart
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [15:0]                  m_tdata;        // [15:0] window_max
	logic                         window_size_we = 1'b0;
	logic [swm_pkg::CFG_BITS-1:0] window_size_wdata = '0;
	int                           mismatches;
	int                           outstanding;
	int                           burst_left = 0;
	int                           sent = 0;

	sliding_window_maximum_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.window_size_we   (window_size_we),
		.window_size_wdata(window_size_wdata)
	);

	window_max_checker u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.window_size_we   (window_size_we),
		.window_size_wdata(window_size_wdata),
		.mismatches       (mismatches),
		.outstanding      (outstanding)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#(8 * LIMIT_CYCLES);
		$display("** sliding_window_maximum_unit: FAILED **");
		$finish;
	end

	// Stall the result side in segments: always ready, coin flips, long stalls, rare stalls
	initial begin
		int mode;
		int seg;
		int hold;
		logic level;
		hold = 0;
		level = 1'b1;
		wait (arst_n);
		forever begin
			mode = $urandom_range(0, 3);
			seg = $urandom_range(50, 300);
			repeat (seg) begin
				@(negedge clk);
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: begin
						if (hold == 0) begin
							level = ~level;
							hold = level ? $urandom_range(1, 10) : $urandom_range(1, 20);
						end
						hold--;
						m_tready <= level;
					end
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Offer one item; open a new burst after a random gap when the current one is used up
	task automatic send_sample(input logic signed [15:0] value, input logic restart);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= value;
		s_tuser <= restart;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		sent++;
	endtask

	// Write the window register once every result is out and the block has settled
	task automatic write_window(input logic [swm_pkg::CFG_BITS-1:0] value);
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		window_size_we <= 1'b1;
		window_size_wdata <= value;
		@(negedge clk);
		window_size_we <= 1'b0;
	endtask

	function automatic logic signed [15:0] pick_sample(pattern_t style, int idx,
			int base, int step);
		if ($urandom_range(0, 15) == 0) begin
			return 16'($urandom);
		end
		case (style)
			NARROW:   return 16'($signed($urandom_range(0, 8)) - 4);
			FALLING:  return 16'(base - idx * step);
			RISING:   return 16'(base + idx * step);
			EXTREMES: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7fff;
					1: return 16'sh8000;
					2: return 16'sh0000;
					default: return 16'shffff;
				endcase
			end
			default:  return 16'($urandom);
		endcase
	endfunction

	initial begin
		pattern_t style;
		int len;
		int base;
		int step;
		int pick;
		logic [swm_pkg::CFG_BITS-1:0] span;
		logic restart;
		logic long_run;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// window of one from reset, extremes of the sample
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		send_sample(16'shffff, 1'b0);
		// falling run fills the window with five deque entries
		write_window(7'd5);
		send_sample(16'sd40, 1'b1);
		send_sample(16'sd30, 1'b0);
		send_sample(16'sd20, 1'b0);
		send_sample(16'sd10, 1'b0);
		send_sample(16'sd0, 1'b0);
		// shrink mid-stream: several front entries age out at once
		write_window(7'd2);
		send_sample(-16'sd100, 1'b0);
		send_sample(-16'sd100, 1'b0);
		// size zero acts as one
		write_window(7'd0);
		send_sample(16'sd7, 1'b0);
		send_sample(16'sh8000, 1'b1);
		// ties, aging and the most negative value
		write_window(7'd3);
		send_sample(16'sh8000, 1'b1);
		send_sample(16'sh7fff, 1'b0);
		send_sample(16'sd5, 1'b0);
		send_sample(16'sd5, 1'b0);
		send_sample(16'shffff, 1'b0);
		send_sample(16'sh8000, 1'b0);
		// oversize window saturates, stream not yet full
		write_window(7'd127);
		send_sample(16'sd1, 1'b1);
		send_sample(16'sd2, 1'b0);
		send_sample(16'sd3, 1'b0);

		// random phases: mostly full streams, some kept across a size change
		sent = 0;
		while (sent < TOTAL_ITEMS) begin
			pick = $urandom_range(0, 9);
			case (pick)
				0: span = 7'd0;
				1: span = 7'd64;
				2: span = 7'($urandom_range(65, 127));
				3: span = 7'd1;
				4, 5: span = 7'($urandom_range(2, 8));
				default: span = 7'($urandom_range(1, 64));
			endcase
			write_window(span);
			long_run = ($urandom_range(0, 4) == 0);
			len = long_run ? $urandom_range(150, 260) : $urandom_range(20, 120);
			style = pattern_t'($urandom_range(0, 4));
			base = (style == FALLING) ? 32767 : -32768;
			step = $urandom_range(1, 100);
			for (int i = 0; i < len; i++) begin
				if (i == 0) begin
					restart = ($urandom_range(0, 9) < 7);
				end else begin
					restart = !long_run && ($urandom_range(0, 149) == 0);
				end
				send_sample(pick_sample(style, i, base, step), restart);
			end
		end

		// let the last results drain, then give the verdict
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("** sliding_window_maximum_unit: PASSED **");
		end else begin
			$display("** sliding_window_maximum_unit: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
rtl/swm_pkg.sv
rtl/swm_cell.sv
rtl/sliding_window_maximum_unit.sv
dv/window_max_checker.sv
dv/sliding_window_maximum_unit_tb.sv
